### hw/rtl/cwc_pkg.sv
// ----------------------------------------------------------------------------
// cwc_pkg: shared types and constants of the waveform crest classifier
// Class codes, classification thresholds and the controller/datapath bundles.
// ----------------------------------------------------------------------------
`default_nettype none

package cwc_pkg;

    localparam int CNT_W     = 16;   // window length / sample count width
    localparam int FRAC_BITS = 16;   // Q0.16 threshold fraction
    localparam int CLASS_W   = 2;

    localparam logic [CNT_W-1:0] WINDOW_RESET = 16'd62500;

    // squared midpoints between adjacent RMS/peak ratios, Q0.16
    localparam logic [FRAC_BITS-1:0] MID_TRI_SINE = 16'd27031;
    localparam logic [FRAC_BITS-1:0] MID_SINE_SQR = 16'd47746;

    localparam logic [CLASS_W-1:0] CLASS_SINE = 2'd0;
    localparam logic [CLASS_W-1:0] CLASS_TRI  = 2'd1;
    localparam logic [CLASS_W-1:0] CLASS_SQR  = 2'd2;

    typedef struct packed {
        logic take;       // sample beat accepted this cycle
        logic mul_sq;     // peak * peak
        logic mul_en;     // count * peak^2
        logic mul_thr;    // energy * both midpoints
        logic load_out;   // decide class, load result register
    } cmd_t;

    typedef struct packed {
        logic win_close;  // the sample now offered closes the window
    } status_t;

endpackage

`default_nettype wire

### hw/rtl/cwc_ctrl.sv
// ----------------------------------------------------------------------------
// cwc_ctrl: sequencing controller
// Accepts samples, walks the datapath through the class computation after
// each closed window and owns the result valid flag.
// ----------------------------------------------------------------------------
`default_nettype none

module cwc_ctrl (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            s_valid,
    output logic                 s_ready,
    output logic                 m_valid,
    input  wire logic            m_ready,
    input  wire cwc_pkg::status_t status,
    output cwc_pkg::cmd_t        cmd
);

    typedef enum logic [2:0] {
        ST_ACC,
        ST_SQ,
        ST_EN,
        ST_THR,
        ST_OUT
    } state_t;

    state_t state_reg;
    logic   out_valid_reg;

    assign s_ready = (state_reg == ST_ACC);
    assign m_valid = out_valid_reg;

    always_comb begin
        cmd          = '0;
        cmd.take     = s_ready && s_valid;
        cmd.mul_sq   = (state_reg == ST_SQ);
        cmd.mul_en   = (state_reg == ST_EN);
        cmd.mul_thr  = (state_reg == ST_THR);
        cmd.load_out = (state_reg == ST_OUT) && (!out_valid_reg || m_ready);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_ACC;
            out_valid_reg <= 1'b0;
        end else begin
            case (state_reg)
                ST_ACC: begin
                    if (cmd.take && status.win_close) state_reg <= ST_SQ;
                end
                ST_SQ:  state_reg <= ST_EN;
                ST_EN:  state_reg <= ST_THR;
                ST_THR: state_reg <= ST_OUT;
                ST_OUT: begin
                    if (cmd.load_out) state_reg <= ST_ACC;
                end
                default: state_reg <= ST_ACC;
            endcase

            if (cmd.load_out) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

endmodule

`default_nettype wire

### hw/rtl/cwc_datapath.sv
// ----------------------------------------------------------------------------
// cwc_datapath: accumulation and classification datapath
// Sum of squares, running peak and sample count per window; at window close
// a snapshot goes through three registered multiply steps and a compare.
// ----------------------------------------------------------------------------
`default_nettype none

module cwc_datapath #(
    parameter int SAMPLE_BITS = 12,
    localparam int ACC_W  = 2 * SAMPLE_BITS + cwc_pkg::CNT_W,
    localparam int PROD_W = ACC_W + cwc_pkg::FRAC_BITS
) (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        cfg_wr_en,
    input  wire logic [cwc_pkg::CNT_W-1:0]   cfg_wr_data,
    input  wire logic [SAMPLE_BITS-1:0]      sample,
    input  wire cwc_pkg::cmd_t               cmd,
    output cwc_pkg::status_t                 status,
    output logic [cwc_pkg::CLASS_W-1:0]      out_class,
    output logic [SAMPLE_BITS-1:0]           out_peak,
    output logic [ACC_W-1:0]                 out_sum
);

    localparam int CNT_W = cwc_pkg::CNT_W;
    localparam int SQ_W  = 2 * SAMPLE_BITS;

    logic [CNT_W-1:0]       window_length_reg;
    logic [ACC_W-1:0]       acc_reg;
    logic [SAMPLE_BITS-1:0] peak_reg;
    logic [CNT_W-1:0]       count_reg;

    logic [ACC_W-1:0]       snap_sum_reg;
    logic [SAMPLE_BITS-1:0] snap_peak_reg;
    logic [CNT_W-1:0]       snap_count_reg;
    logic [SQ_W-1:0]        pk_sq_reg;
    logic [ACC_W-1:0]       energy_reg;
    logic [PROD_W-1:0]      thr_lo_reg;
    logic [PROD_W-1:0]      thr_hi_reg;

    logic [ACC_W-1:0]       acc_next;
    logic [SAMPLE_BITS-1:0] peak_next;
    logic [CNT_W:0]         count_next;
    logic [CNT_W:0]         limit;
    logic [PROD_W-1:0]      scaled_sum;
    logic [cwc_pkg::CLASS_W-1:0] class_next;

    assign acc_next   = acc_reg + ACC_W'(SQ_W'(sample) * SQ_W'(sample));
    assign peak_next  = (sample > peak_reg) ? sample : peak_reg;
    assign count_next = {1'b0, count_reg} + 1'b1;
    // a zero window length acts as a one-sample window
    assign limit      = (window_length_reg == '0) ? (CNT_W+1)'(1)
                                                  : {1'b0, window_length_reg};
    assign status.win_close = (count_next >= limit);

    assign scaled_sum = {snap_sum_reg, {cwc_pkg::FRAC_BITS{1'b0}}};

    always_comb begin
        if (snap_peak_reg == '0) begin
            class_next = cwc_pkg::CLASS_SQR;
        end else if (scaled_sum <= thr_lo_reg) begin
            class_next = cwc_pkg::CLASS_TRI;
        end else if (scaled_sum >= thr_hi_reg) begin
            class_next = cwc_pkg::CLASS_SQR;
        end else begin
            class_next = cwc_pkg::CLASS_SINE;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            window_length_reg <= cwc_pkg::WINDOW_RESET;
            acc_reg           <= '0;
            peak_reg          <= '0;
            count_reg         <= '0;
        end else begin
            if (cfg_wr_en) window_length_reg <= cfg_wr_data;
            if (cmd.take) begin
                if (status.win_close) begin
                    acc_reg   <= '0;
                    peak_reg  <= '0;
                    count_reg <= '0;
                end else begin
                    acc_reg   <= acc_next;
                    peak_reg  <= peak_next;
                    count_reg <= count_next[CNT_W-1:0];
                end
            end
        end
    end

    // payload registers, no reset
    always_ff @(posedge aclk) begin
        if (cmd.take && status.win_close) begin
            snap_sum_reg   <= acc_next;
            snap_peak_reg  <= peak_next;
            snap_count_reg <= count_next[CNT_W-1:0];
        end
        if (cmd.mul_sq) pk_sq_reg <= SQ_W'(snap_peak_reg) * SQ_W'(snap_peak_reg);
        if (cmd.mul_en) energy_reg <= ACC_W'(snap_count_reg) * ACC_W'(pk_sq_reg);
        if (cmd.mul_thr) begin
            thr_lo_reg <= PROD_W'(energy_reg) * PROD_W'(cwc_pkg::MID_TRI_SINE);
            thr_hi_reg <= PROD_W'(energy_reg) * PROD_W'(cwc_pkg::MID_SINE_SQR);
        end
        if (cmd.load_out) begin
            out_class <= class_next;
            out_peak  <= snap_peak_reg;
            out_sum   <= snap_sum_reg;
        end
    end

endmodule

`default_nettype wire

### hw/rtl/waveform_crest_classifier_unit.sv
// After the beat that closes a window, ST_SQ, ST_EN, ST_THR and ST_OUT run in turn before m_axis_tvalid rises.
// Throughput: one sample beat per cycle inside a window; after the closing
// beat the input stalls for the class multiplies and compare, and longer
// while the previous result still sits unaccepted in the output register.
// Reset (aresetn low, synchronous): clears sums, peak and count, loads a
// window length of 62500 and drops any pending result.
// ----------------------------------------------------------------------------
// waveform_crest_classifier_unit: crest factor waveform classifier
// Accumulates squares and peak of ADC samples per window and classifies the
// waveform as triangle, sine or square from RMS versus peak.
// ----------------------------------------------------------------------------
`default_nettype none

module waveform_crest_classifier_unit #(
    parameter int SAMPLE_BITS = 12,
    localparam int ACC_W   = 2 * SAMPLE_BITS + cwc_pkg::CNT_W,
    localparam int IN_W    = ((SAMPLE_BITS + 7) / 8) * 8,
    localparam int FIELD_W = cwc_pkg::CLASS_W + SAMPLE_BITS + ACC_W,
    localparam int OUT_W   = ((FIELD_W + 7) / 8) * 8
) (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      cfg_wr_en,
    input  wire logic [cwc_pkg::CNT_W-1:0] cfg_wr_data,    // window_length
    input  wire logic                      s_axis_tvalid,
    output logic                           s_axis_tready,
    input  wire logic [IN_W-1:0]           s_axis_tdata,   // sample
    output logic                           m_axis_tvalid,
    input  wire logic                      m_axis_tready,
    output logic [OUT_W-1:0]               m_axis_tdata    // wave_class, peak, sum_squares
);

    cwc_pkg::cmd_t    cmd;
    cwc_pkg::status_t status;

    logic [cwc_pkg::CLASS_W-1:0] out_class;
    logic [SAMPLE_BITS-1:0]      out_peak;
    logic [ACC_W-1:0]            out_sum;

    cwc_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_axis_tvalid),
        .s_ready (s_axis_tready),
        .m_valid (m_axis_tvalid),
        .m_ready (m_axis_tready),
        .status  (status),
        .cmd     (cmd)
    );

    cwc_datapath #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .sample      (s_axis_tdata[SAMPLE_BITS-1:0]),
        .cmd         (cmd),
        .status      (status),
        .out_class   (out_class),
        .out_peak    (out_peak),
        .out_sum     (out_sum)
    );

    assign m_axis_tdata = OUT_W'({out_sum, out_peak, out_class});

endmodule

`default_nettype wire

### hw/rtl/cwc_checker.sv
// ----------------------------------------------------------------------------
// cwc_checker: port-level checks for the crest classifier
// Watches the result channel for reset, hold and value consistency.
// ----------------------------------------------------------------------------
`default_nettype none

module cwc_checker #(
    parameter int SAMPLE_BITS = 12,
    localparam int ACC_W   = 2 * SAMPLE_BITS + cwc_pkg::CNT_W,
    localparam int FIELD_W = cwc_pkg::CLASS_W + SAMPLE_BITS + ACC_W,
    localparam int OUT_W   = ((FIELD_W + 7) / 8) * 8
) (
    input wire logic             aclk,
    input wire logic             aresetn,
    input wire logic             m_axis_tvalid,
    input wire logic             m_axis_tready,
    input wire logic [OUT_W-1:0] m_axis_tdata
);

    localparam int PK_LO  = cwc_pkg::CLASS_W;
    localparam int SUM_LO = cwc_pkg::CLASS_W + SAMPLE_BITS;

    logic [cwc_pkg::CLASS_W-1:0] cls;
    logic [SAMPLE_BITS-1:0]      pk;
    logic [ACC_W-1:0]            sum;

    assign cls = m_axis_tdata[cwc_pkg::CLASS_W-1:0];
    assign pk  = m_axis_tdata[SUM_LO-1:PK_LO];
    assign sum = m_axis_tdata[FIELD_W-1:SUM_LO];

    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !m_axis_tvalid)
        else $error("result valid after reset");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result beat changed");

    a_class_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> (cls == cwc_pkg::CLASS_SINE) || (cls == cwc_pkg::CLASS_TRI)
                          || (cls == cwc_pkg::CLASS_SQR))
        else $error("class code out of range");

    a_zero_peak: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && (pk == '0) |-> (cls == cwc_pkg::CLASS_SQR))
        else $error("zero peak not classed square");

    // the peak sample itself is part of the sum
    a_sum_covers_peak: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> (sum >= ACC_W'(ACC_W'(pk) * ACC_W'(pk))))
        else $error("sum of squares below peak squared");

endmodule

bind waveform_crest_classifier_unit cwc_checker #(
    .SAMPLE_BITS (SAMPLE_BITS)
) u_cwc_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire

### bench/tb_waveform_crest_classifier_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_waveform_crest_classifier_unit: self-checking bench of the crest classifier
// Streams ADC samples through windows of many lengths, tracks sum of squares,
// peak and class in a scoreboard and checks every result beat field by field.
// ----------------------------------------------------------------------------

typedef struct {
    logic [cwc_pkg::CLASS_W-1:0] wave_class;
    logic [11:0]                 peak;
    logic [39:0]                 sum_squares;
} crest_report_t;

class crest_ledger;
    logic [15:0]   window_len;
    logic [39:0]   sq_sum;
    logic [11:0]   top_sample;
    logic [15:0]   taken;
    crest_report_t pending[$];
    int            errors;

    function new();
        window_len = cwc_pkg::WINDOW_RESET;
        sq_sum     = '0;
        top_sample = '0;
        taken      = '0;
        errors     = 0;
    endfunction

    function void set_window(logic [15:0] len);
        window_len = len;
    endfunction

    function void flag(string msg);
        errors++;
        if (errors <= 10) $display("[%0t] ERROR: %s", $realtime, msg);
    endfunction

    // no roots or division: sum * 2^16 against n * peak^2 * squared midpoint
    function logic [cwc_pkg::CLASS_W-1:0] crest_class(logic [39:0] sum, logic [11:0] pk,
                                                       logic [16:0] n);
        logic [63:0] scaled;
        logic [63:0] energy;
        if (pk == 12'd0) return cwc_pkg::CLASS_SQR;
        scaled = {24'd0, sum} << 16;
        energy = 64'(n) * 64'(pk) * 64'(pk);
        if (scaled <= energy * 64'(cwc_pkg::MID_TRI_SINE)) return cwc_pkg::CLASS_TRI;
        if (scaled >= energy * 64'(cwc_pkg::MID_SINE_SQR)) return cwc_pkg::CLASS_SQR;
        return cwc_pkg::CLASS_SINE;
    endfunction

    function void note_sample(logic [11:0] s);
        logic [16:0]   limit;
        logic [16:0]   count;
        crest_report_t rep;
        limit  = (window_len == 16'd0) ? 17'd1 : {1'b0, window_len};
        sq_sum = sq_sum + 40'(s) * 40'(s);
        if (s > top_sample) top_sample = s;
        count = {1'b0, taken} + 17'd1;
        if (count < limit) begin
            taken = count[15:0];
            return;
        end
        rep.wave_class  = crest_class(sq_sum, top_sample, count);
        rep.peak        = top_sample;
        rep.sum_squares = sq_sum;
        pending.push_back(rep);
        sq_sum     = '0;
        top_sample = '0;
        taken      = '0;
    endfunction

    function void check_report(logic [55:0] beat);
        crest_report_t want;
        logic [1:0]    got_class;
        logic [11:0]   got_peak;
        logic [39:0]   got_sum;
        got_class = beat[1:0];
        got_peak  = beat[13:2];
        got_sum   = beat[53:14];
        if (pending.size() == 0) begin
            flag($sformatf("unexpected result class=%0d peak=%0d sum=%0d",
                           got_class, got_peak, got_sum));
            return;
        end
        want = pending.pop_front();
        if (got_class != want.wave_class)
            flag($sformatf("wave_class exp %0d got %0d", want.wave_class, got_class));
        if (got_peak != want.peak)
            flag($sformatf("peak exp %0d got %0d", want.peak, got_peak));
        if (got_sum != want.sum_squares)
            flag($sformatf("sum_squares exp %0d got %0d", want.sum_squares, got_sum));
    endfunction
endclass

module tb_waveform_crest_classifier_unit;

    localparam int STALL_LIMIT = 2000;
    localparam int SETTLE      = 12;   // extra wait in wait_drained after the last result
    localparam int DIRECTED    = 49;
    localparam int PER_PHASE   = 330;

    logic        aclk;
    logic        aresetn       = 1'b0;
    logic        cfg_wr_en     = 1'b0;
    logic [15:0] cfg_wr_data   = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata  = '0;   // sample[11:0], zero pad
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [55:0] m_axis_tdata;         // wave_class[1:0], peak[13:2], sum_squares[53:14]

    int src_idle_pct  = 0;
    int sink_idle_pct = 0;
    int sent_count    = 0;
    int stall_cycles  = 0;

    crest_ledger ledger = new();

    waveform_crest_classifier_unit DUT (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // result side: check accepted beats, stall at random
    always @(posedge aclk) begin
        if (aresetn && m_axis_tvalid && m_axis_tready)
            ledger.check_report(m_axis_tdata);
        m_axis_tready <= ($urandom_range(99) >= sink_idle_pct);
    end

    always @(posedge aclk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("Verification failed");
                $finish;
            end
        end
    end

    task automatic send_sample(input logic [11:0] s);
        while ($urandom_range(99) < src_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {4'd0, s};
        do @(posedge aclk); while (!s_axis_tready);
        ledger.note_sample(s);
        sent_count++;
    endtask

    // hold the input until every result is out and the datapath has settled
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (ledger.pending.size() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic set_window(input logic [15:0] len);
        wait_drained();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= len;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        ledger.set_window(len);
    endtask

    // count beats shaped after one window of n samples
    task automatic send_shaped(input int count, input int n, input int shape);
        logic [11:0] pk;
        logic [11:0] s;
        int          spot;
        case ($urandom_range(3))
            0:       pk = 12'hFFF;
            1:       pk = 12'($urandom_range(1, 15));
            default: pk = 12'($urandom_range(4095));
        endcase
        spot = $urandom_range(n - 1);
        for (int i = 0; i < count; i++) begin
            case (shape)
                0:       s = 12'($urandom_range(4095));
                1:       s = pk;
                2:       s = 12'((int'(pk) * (i + 1)) / n);      // ramp
                3:       s = (i == spot) ? pk : 12'd0;           // lone spike
                4:       s = 12'd0;
                5:       s = i[0] ? 12'($urandom_range(int'(pk) / 8)) : pk;
                default: s = 12'($urandom_range(int'(pk)));
            endcase
            send_sample(s);
        end
    endtask

    initial begin
        int len;
        int n;
        int shape;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        src_idle_pct  = 16;
        sink_idle_pct = 78;

        // open a window at the reset length; the shrink below closes it
        repeat (20) send_sample(12'($urandom_range(4095)));

        // single-sample windows: zero peak gives square
        set_window(16'd1);
        send_sample(12'd0);
        send_sample(12'd0);
        send_sample(12'hFFF);
        send_sample(12'd1);
        // zero length acts as one
        set_window(16'd0);
        send_sample(12'hA5C);
        set_window(16'd2);
        send_sample(12'hFFF);
        send_sample(12'd0);
        // exactly on the triangle/sine midpoint
        set_window(16'd8);
        send_sample(12'd128);
        send_sample(12'd128);
        send_sample(12'd128);
        send_sample(12'd70);
        send_sample(12'd3);
        send_sample(12'd1);
        send_sample(12'd0);
        send_sample(12'd0);
        // exactly on the sine/square midpoint
        repeat (5) send_sample(12'd128);
        send_sample(12'd116);
        send_sample(12'd10);
        send_sample(12'd4);
        // shrink below the count mid-window: closes on the next sample
        send_sample(12'd300);
        send_sample(12'd0);
        send_sample(12'd0);
        send_sample(12'd0);
        send_sample(12'd0);
        set_window(16'd3);
        send_sample(12'd0);

        for (int ph = 0; ph < 3; ph++) begin
            src_idle_pct  = (ph == 0) ? 16 : (ph == 1) ? 78 : 0;
            sink_idle_pct = (ph == 0) ? 78 : (ph == 1) ? 16 : 0;
            while (sent_count < DIRECTED + (ph + 1) * PER_PHASE) begin
                case ($urandom_range(19))
                    0, 1:    len = 0;
                    2, 3, 4: len = $urandom_range(9, 40);
                    5:       len = $urandom_range(41, 100);
                    default: len = $urandom_range(1, 8);
                endcase
                set_window(16'(len));
                n = (len == 0) ? 1 : len;
                repeat ($urandom_range(1, 4)) begin
                    shape = $urandom_range(6);
                    send_shaped(n, n, shape);
                end
                // leave a window open so the next length change lands mid-window
                if ($urandom_range(1) == 1 && n > 1)
                    send_shaped($urandom_range(1, n - 1), n, $urandom_range(6));
            end
        end

        // full-scale window
        set_window(16'd64);
        repeat (64) send_sample(12'hFFF);

        wait_drained();
        if (ledger.errors == 0 && ledger.pending.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
